// ===== design/quaternion_to_shaft_blade_angles_defines.svh =====
// Assertion macros shared by the quaternion to shaft and blade angle design.
`ifndef QUATERNION_TO_SHAFT_BLADE_ANGLES_DEFINES_SVH
`define QUATERNION_TO_SHAFT_BLADE_ANGLES_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define QSBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked while reset is active.
`define QSBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/qsba_pkg.sv =====
// Package with widths, limits and the CORDIC angle table for the angle pipeline.
`timescale 1ns / 1ps
package qsba_pkg;

    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STAGES_DEF  = 16;

    localparam int QUAT_W    = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 35;
    localparam int CORD_IN_W = 35;
    localparam int CORD_W    = 56;
    localparam int ANG_W     = 26;
    localparam int HUND_W    = 34;
    localparam int ROT_W     = 16;
    localparam int TILT_W    = 15;
    localparam int SQ_W      = 63;
    localparam int ISQ_STEPS = 32;

    localparam int ROT_LIM  = 18000;
    localparam int TILT_LIM = 9000;

    // atan(2^-i) in units of 2^-16 degree; entries past 22 are zero.
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = ANG_W'(2949120);
            5'd1:    v = ANG_W'(1740967);
            5'd2:    v = ANG_W'(919879);
            5'd3:    v = ANG_W'(466945);
            5'd4:    v = ANG_W'(234379);
            5'd5:    v = ANG_W'(117304);
            5'd6:    v = ANG_W'(58666);
            5'd7:    v = ANG_W'(29335);
            5'd8:    v = ANG_W'(14668);
            5'd9:    v = ANG_W'(7334);
            5'd10:   v = ANG_W'(3667);
            5'd11:   v = ANG_W'(1833);
            5'd12:   v = ANG_W'(917);
            5'd13:   v = ANG_W'(458);
            5'd14:   v = ANG_W'(229);
            5'd15:   v = ANG_W'(115);
            5'd16:   v = ANG_W'(57);
            5'd17:   v = ANG_W'(29);
            5'd18:   v = ANG_W'(14);
            5'd19:   v = ANG_W'(7);
            5'd20:   v = ANG_W'(4);
            5'd21:   v = ANG_W'(2);
            5'd22:   v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Rounds 2^-16 units to the nearest integer, halves away from zero, then saturates.
    function automatic logic signed [ROT_W-1:0] round_sat(
        input logic signed [HUND_W-1:0] h,
        input logic signed [HUND_W-1:0] lim
    );
        logic signed [HUND_W-1:0] mag;
        logic signed [HUND_W-1:0] q;
        mag = (h < 0) ? -h : h;
        q   = (mag + HUND_W'(32768)) >>> 16;
        q   = (h < 0) ? -q : q;
        if (q > lim) begin
            q = lim;
        end
        if (q < -lim) begin
            q = -lim;
        end
        return q[ROT_W-1:0];
    endfunction

endpackage

// ===== design/quaternion_to_shaft_blade_angles.sv =====
// Top level: quaternion to shaft rotation, shaft tilt and blade rotation pipeline.
//
//   Channel   Valid         Ready         Payload
//   input     i_in_valid    o_in_ready    i_quat_w, i_quat_x, i_quat_y, i_quat_z
//   output    o_out_valid   i_out_ready   o_shaft_rotation, o_shaft_tilt,
//                                         o_blade_rotation, o_no_heading
//
// One item is accepted per cycle unless the output is held. There are CORDIC_STAGES + 39
// register stages; the depth is set by the 32-step integer square root for the tilt
// cosine and the CORDIC stages.
// Reset clears only the valid bits; the data registers need none.
// Input ready is low during reset. When the output is held, the whole pipeline
// freezes and input ready drops.
`timescale 1ns / 1ps
`include "quaternion_to_shaft_blade_angles_defines.svh"
module quaternion_to_shaft_blade_angles #(
    parameter int QUAT_FRAC_BITS = qsba_pkg::QUAT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES  = qsba_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [qsba_pkg::QUAT_W-1:0]   i_quat_w,
    input  logic signed [qsba_pkg::QUAT_W-1:0]   i_quat_x,
    input  logic signed [qsba_pkg::QUAT_W-1:0]   i_quat_y,
    input  logic signed [qsba_pkg::QUAT_W-1:0]   i_quat_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [qsba_pkg::ROT_W-1:0]    o_shaft_rotation,
    output logic signed [qsba_pkg::TILT_W-1:0]   o_shaft_tilt,
    output logic signed [qsba_pkg::ROT_W-1:0]    o_blade_rotation,
    output logic                                 o_no_heading
);

    localparam int PW   = qsba_pkg::PROD_W;
    localparam int SW   = qsba_pkg::SUM_W;
    localparam int CW   = qsba_pkg::CORD_IN_W;
    localparam int QW   = qsba_pkg::SQ_W;
    localparam int HW   = qsba_pkg::HUND_W;
    localparam int NSTP = qsba_pkg::ISQ_STEPS;
    localparam int SH_R = (2 * QUAT_FRAC_BITS >= 30) ? 2 * QUAT_FRAC_BITS - 30 : 0;
    localparam int SH_L = (2 * QUAT_FRAC_BITS < 30) ? 30 - 2 * QUAT_FRAC_BITS : 0;
    localparam int DLY  = NSTP + 2;
    localparam int LAT  = DLY + 2 + CORDIC_STAGES + 1 + 2;

    logic en;
    logic r_vld [0:LAT-1];

    // The whole pipeline advances unless a finished item is held at the output.
    assign en          = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = en && i_rst_n;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 1: all pairwise products.
    logic signed [PW-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_yz, r_wx, r_xz, r_wy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ww <= i_quat_w * i_quat_w;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;
            r_yz <= i_quat_y * i_quat_z;
            r_wx <= i_quat_w * i_quat_x;
            r_xz <= i_quat_x * i_quat_z;
            r_wy <= i_quat_w * i_quat_y;
        end
    end

    // Stage 2: rotated vector components and the clamped tilt sine in Q30.
    logic signed [SW-1:0] n_sx, n_sy, n_sz, n_vx, n_vz;
    logic signed [SW-1:0] r_sx, r_sy, r_vx, r_vz;
    logic signed [63:0]   sz_cl;
    logic signed [63:0]   one_q;
    logic signed [63:0]   s_q30;
    logic signed [31:0]   r_s30;

    always_comb begin
        n_sx  = (SW'(r_xy) - SW'(r_wz)) <<< 1;
        n_sy  = SW'(r_ww) - SW'(r_xx) + SW'(r_yy) - SW'(r_zz);
        n_sz  = (SW'(r_yz) + SW'(r_wx)) <<< 1;
        n_vx  = (SW'(r_xz) - SW'(r_wy)) <<< 1;
        n_vz  = SW'(r_ww) - SW'(r_xx) - SW'(r_yy) + SW'(r_zz);
        one_q = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
        sz_cl = 64'(n_sz);
        if (sz_cl > one_q) begin
            sz_cl = one_q;
        end
        if (sz_cl < -one_q) begin
            sz_cl = -one_q;
        end
        s_q30 = (sz_cl >>> SH_R) <<< SH_L;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_vx  <= n_vx;
            r_vz  <= n_vz;
            r_s30 <= s_q30[31:0];
        end
    end

    // Stages 3 and 4: square of the sine, then the radicand 2^60 - s^2.
    logic [QW-1:0]      r_sq;
    logic [QW-1:0]      r_rem;
    logic signed [63:0] s30_w;

    // The sine is widened first so that its square keeps every bit.
    assign s30_w = 64'(r_s30);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq  <= QW'(s30_w * s30_w);
            r_rem <= (QW'(1) << 60) - r_sq;
        end
    end

    // Integer square root, one result bit per stage.
    logic [QW-1:0] r_n [0:NSTP-1];
    logic [QW-1:0] r_r [0:NSTP-1];

    for (genvar k = 0; k < NSTP; k++) begin : g_isqrt
        localparam logic [QW-1:0] B = QW'(1) << (2 * (NSTP - 1 - k));
        logic [QW-1:0] n_in;
        logic [QW-1:0] r_in;
        logic [QW:0]   t;
        always_comb begin
            n_in = (k == 0) ? r_rem : r_n[(k == 0) ? 0 : k - 1];
            r_in = (k == 0) ? '0 : r_r[(k == 0) ? 0 : k - 1];
            t    = {1'b0, r_in} + {1'b0, B};
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if ({1'b0, n_in} >= t) begin
                    r_n[k] <= n_in - t[QW-1:0];
                    r_r[k] <= (r_in >> 1) + B;
                end else begin
                    r_n[k] <= n_in;
                    r_r[k] <= r_in >> 1;
                end
            end
        end
    end

    // Delay lines that align the other operands with the square root result.
    logic signed [SW-1:0] r_d_sx  [0:DLY-1];
    logic signed [SW-1:0] r_d_sy  [0:DLY-1];
    logic signed [SW-1:0] r_d_vx  [0:DLY-1];
    logic signed [SW-1:0] r_d_vz  [0:DLY-1];
    logic signed [31:0]   r_d_s30 [0:DLY-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sx[0]  <= r_sx;
            r_d_sy[0]  <= r_sy;
            r_d_vx[0]  <= r_vx;
            r_d_vz[0]  <= r_vz;
            r_d_s30[0] <= r_s30;
            for (int k = 1; k < DLY; k++) begin
                r_d_sx[k]  <= r_d_sx[k-1];
                r_d_sy[k]  <= r_d_sy[k-1];
                r_d_vx[k]  <= r_d_vx[k-1];
                r_d_vz[k]  <= r_d_vz[k-1];
                r_d_s30[k] <= r_d_s30[k-1];
            end
        end
    end

    // Three CORDIC units run side by side.
    logic signed [qsba_pkg::ANG_W-1:0] ang_rot, ang_tilt, ang_blade;
    logic                              rot_zero, tilt_zero, blade_zero;

    qsba_cordic #(.STAGES(CORDIC_STAGES)) u_rot (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (CW'(-r_d_sx[DLY-1])),
        .i_x    (CW'(r_d_sy[DLY-1])),
        .o_ang  (ang_rot),
        .o_zero (rot_zero)
    );

    qsba_cordic #(.STAGES(CORDIC_STAGES)) u_tilt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (CW'(r_d_s30[DLY-1])),
        .i_x    (signed'(CW'(r_r[NSTP-1]))),
        .o_ang  (ang_tilt),
        .o_zero (tilt_zero)
    );

    qsba_cordic #(.STAGES(CORDIC_STAGES)) u_blade (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (CW'(r_d_vx[DLY-1])),
        .i_x    (CW'(r_d_vz[DLY-1])),
        .o_ang  (ang_blade),
        .o_zero (blade_zero)
    );

    // Scale to hundredths, then round and saturate into the output register.
    logic signed [HW-1:0] r_h_rot, r_h_tilt, r_h_blade;
    logic                 r_h_nh;
    logic signed [qsba_pkg::ROT_W-1:0]  r_o_rot, r_o_blade, tilt_full;
    logic signed [qsba_pkg::TILT_W-1:0] r_o_tilt;
    logic                               r_o_nh;

    assign tilt_full = qsba_pkg::round_sat(r_h_tilt, HW'(qsba_pkg::TILT_LIM));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_rot   <= HW'(ang_rot) * HW'(100);
            r_h_tilt  <= tilt_zero ? '0 : HW'(ang_tilt) * HW'(100);
            r_h_blade <= blade_zero ? '0 : HW'(ang_blade) * HW'(100);
            r_h_nh    <= rot_zero;
            r_o_rot   <= qsba_pkg::round_sat(r_h_rot, HW'(qsba_pkg::ROT_LIM));
            r_o_tilt  <= tilt_full[qsba_pkg::TILT_W-1:0];
            r_o_blade <= qsba_pkg::round_sat(r_h_blade, HW'(qsba_pkg::ROT_LIM));
            r_o_nh    <= r_h_nh;
        end
    end

    assign o_shaft_rotation = r_o_rot;
    assign o_shaft_tilt     = r_o_tilt;
    assign o_blade_rotation = r_o_blade;
    assign o_no_heading     = r_o_nh;

    // Checks on the result and on reset behaviour.
    `QSBA_ASSERT_IMPL(a_nh_rot_zero, o_out_valid && o_no_heading, o_shaft_rotation == 0, "flag set")
    `QSBA_ASSERT_IMPL(a_tilt_range, o_out_valid, (o_shaft_tilt <= 9000) && (o_shaft_tilt >= -9000), "tilt")
    `QSBA_ASSERT_IMPL(a_rot_range, o_out_valid, (o_shaft_rotation <= 18000) && (o_shaft_rotation >= -18000), "rot")
    `QSBA_ASSERT_IMPL(a_blade_range, o_out_valid, (o_blade_rotation <= 18000) && (o_blade_rotation >= -18000), "blade")
    `QSBA_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_out_valid, "output valid after reset")

endmodule

// ===== design/qsba_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in units of 2^-16 degree.
`timescale 1ns / 1ps
module qsba_cordic #(
    parameter int STAGES = qsba_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic signed [qsba_pkg::CORD_IN_W-1:0]    i_y,
    input  logic signed [qsba_pkg::CORD_IN_W-1:0]    i_x,
    output logic signed [qsba_pkg::ANG_W-1:0]        o_ang,
    output logic                                     o_zero
);

    localparam int W  = qsba_pkg::CORD_W;
    localparam int AW = qsba_pkg::ANG_W;

    logic signed [W-1:0]  r_x [0:STAGES];
    logic signed [W-1:0]  r_y [0:STAGES];
    logic signed [AW-1:0] r_a [0:STAGES];
    logic                 r_z [0:STAGES];

    logic signed [W-1:0]  n_x0;
    logic signed [W-1:0]  n_y0;
    logic signed [AW-1:0] n_a0;
    logic signed [W-1:0]  xs;
    logic signed [W-1:0]  ys;

    // Scale by 2^16 and fold the left half plane onto the right one.
    always_comb begin
        xs   = W'(i_x) <<< 16;
        ys   = W'(i_y) <<< 16;
        n_x0 = xs;
        n_y0 = ys;
        n_a0 = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                n_x0 = ys;
                n_y0 = -xs;
                n_a0 = AW'(90 * 65536);
            end else begin
                n_x0 = -ys;
                n_y0 = xs;
                n_a0 = -AW'(90 * 65536);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_a[0] <= n_a0;
            r_z[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[i+1] <= r_z[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] + qsba_pkg::atan_entry(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] - qsba_pkg::atan_entry(5'(i));
                end
            end
        end
    end

    // A zero vector has no angle and reads as zero.
    assign o_ang  = r_z[STAGES] ? '0 : r_a[STAGES];
    assign o_zero = r_z[STAGES];

endmodule

// ===== test/quaternion_to_shaft_blade_angles_checker.sv =====
// Checker for the quaternion to shaft and blade angle pipeline: predicts and compares results.
`timescale 1ns / 1ps
module quaternion_to_shaft_blade_angles_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [qsba_pkg::QUAT_W-1:0]  i_quat_w,
    input  logic signed [qsba_pkg::QUAT_W-1:0]  i_quat_x,
    input  logic signed [qsba_pkg::QUAT_W-1:0]  i_quat_y,
    input  logic signed [qsba_pkg::QUAT_W-1:0]  i_quat_z,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [qsba_pkg::ROT_W-1:0]   i_shaft_rotation,
    input  logic signed [qsba_pkg::TILT_W-1:0]  i_shaft_tilt,
    input  logic signed [qsba_pkg::ROT_W-1:0]   i_blade_rotation,
    input  logic                                i_no_heading,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);

    localparam int FRAC   = qsba_pkg::QUAT_FRAC_BITS_DEF;
    localparam int STAGES = qsba_pkg::CORDIC_STAGES_DEF;
    localparam int ROT_W  = qsba_pkg::ROT_W;
    localparam int TILT_W = qsba_pkg::TILT_W;

    typedef struct packed {
        logic signed [ROT_W-1:0]  shaft_rotation;
        logic signed [TILT_W-1:0] shaft_tilt;
        logic signed [ROT_W-1:0]  blade_rotation;
        logic                     no_heading;
    } angles_t;

    angles_t angle_queue[$];

    // atan(2^-i) in degrees scaled by 2^16, one entry per CORDIC micro-rotation.
    longint atan_steps[32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    // Vectoring CORDIC; the angle comes back in 2^-16 degree.
    function automatic longint vector_angle(input longint ay, input longint ax);
        longint ang;
        longint t;
        longint dx;
        longint dy;
        ang = 0;
        if (ax == 0 && ay == 0) begin
            return 0;
        end
        ax = ax * 65536;
        ay = ay * 65536;
        if (ax < 0) begin
            t = ax;
            if (ay >= 0) begin
                ax = ay; ay = -t; ang = 90 * 65536;
            end else begin
                ax = -ay; ay = t; ang = -90 * 65536;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = ax >>> i;
            dy = ay >>> i;
            if (ay > 0) begin
                ax += dy; ay -= dx; ang += atan_steps[i];
            end else begin
                ax -= dy; ay += dx; ang -= atan_steps[i];
            end
        end
        return ang;
    endfunction

    // Rounds to hundredths of a degree, halves away from zero, then saturates.
    function automatic longint centidegrees(input longint ang, input longint lim);
        longint h;
        longint r;
        h = ang * 100;
        if (h >= 0) begin
            r = (h + 32768) / 65536;
        end else begin
            r = -((-h + 32768) / 65536);
        end
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Rotates the shaft axis and the world vertical, then derives the three angles.
    function automatic angles_t paddle_angles(input longint w, input longint x,
                                              input longint y, input longint z);
        angles_t res;
        longint sx;
        longint sy;
        longint sz;
        longint vx;
        longint vz;
        longint one;
        longint s30;
        longint c;
        sx  = 2 * (x * y - w * z);
        sy  = w * w - x * x + y * y - z * z;
        sz  = 2 * (y * z + w * x);
        vx  = 2 * (x * z - w * y);
        vz  = w * w - x * x - y * y + z * z;
        one = longint'(1) << (2 * FRAC);
        if (sx == 0 && sy == 0) begin
            res.shaft_rotation = '0;
            res.no_heading     = 1'b1;
        end else begin
            res.shaft_rotation = ROT_W'(centidegrees(vector_angle(-sx, sy),
                                                     qsba_pkg::ROT_LIM));
            res.no_heading     = 1'b0;
        end
        if (sz > one) sz = one;
        if (sz < -one) sz = -one;
        if (2 * FRAC >= 30) begin
            s30 = sz >>> (2 * FRAC - 30);
        end else begin
            s30 = sz * (longint'(1) << (30 - 2 * FRAC));
        end
        c = longint'(floor_sqrt((64'd1 << 60) - longint'(s30 * s30)));
        res.shaft_tilt     = TILT_W'(centidegrees(vector_angle(s30, c), qsba_pkg::TILT_LIM));
        res.blade_rotation = ROT_W'(centidegrees(vector_angle(vx, vz), qsba_pkg::ROT_LIM));
        return res;
    endfunction

    // Queue a prediction for each accepted item and compare each delivered result.
    always @(posedge i_clk) begin
        angles_t want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                angle_queue.push_back(paddle_angles(i_quat_w, i_quat_x, i_quat_y, i_quat_z));
            end
            if (i_out_valid && i_out_ready) begin
                if (angle_queue.size() == 0) begin
                    $error("result with no item outstanding");
                    o_fail_count++;
                end else begin
                    want = angle_queue.pop_front();
                    o_checked++;
                    if (i_shaft_rotation !== want.shaft_rotation) begin
                        $error("shaft_rotation expected %0d got %0d",
                               want.shaft_rotation, i_shaft_rotation);
                        o_fail_count++;
                    end
                    if (i_shaft_tilt !== want.shaft_tilt) begin
                        $error("shaft_tilt expected %0d got %0d",
                               want.shaft_tilt, i_shaft_tilt);
                        o_fail_count++;
                    end
                    if (i_blade_rotation !== want.blade_rotation) begin
                        $error("blade_rotation expected %0d got %0d",
                               want.blade_rotation, i_blade_rotation);
                        o_fail_count++;
                    end
                    if (i_no_heading !== want.no_heading) begin
                        $error("no_heading expected %0d got %0d",
                               want.no_heading, i_no_heading);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = angle_queue.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

endmodule

// ===== test/quaternion_to_shaft_blade_angles_tb.sv =====
// Testbench top: stimulus, flow control and verdict for the angle pipeline.
`timescale 1ns / 1ps
module quaternion_to_shaft_blade_angles_tb;

    localparam int QUAT_W = qsba_pkg::QUAT_W;
    localparam int ROT_W  = qsba_pkg::ROT_W;
    localparam int TILT_W = qsba_pkg::TILT_W;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [QUAT_W-1:0]  i_quat_w = '0;
    logic signed [QUAT_W-1:0]  i_quat_x = '0;
    logic signed [QUAT_W-1:0]  i_quat_y = '0;
    logic signed [QUAT_W-1:0]  i_quat_z = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [ROT_W-1:0]   o_shaft_rotation;
    logic signed [TILT_W-1:0]  o_shaft_tilt;
    logic signed [ROT_W-1:0]   o_blade_rotation;
    logic                      o_no_heading;

    int fail_count;
    int pending;
    int checked;
    int send_idle_pct  = 0;
    int drain_stall_pct = 0;
    int sent = 0;

    always #5 i_clk = ~i_clk;

    quaternion_to_shaft_blade_angles uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_quat_w(i_quat_w), .i_quat_x(i_quat_x), .i_quat_y(i_quat_y), .i_quat_z(i_quat_z),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_shaft_rotation(o_shaft_rotation), .o_shaft_tilt(o_shaft_tilt),
        .o_blade_rotation(o_blade_rotation), .o_no_heading(o_no_heading)
    );

    quaternion_to_shaft_blade_angles_checker angle_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_quat_w(i_quat_w), .i_quat_x(i_quat_x), .i_quat_y(i_quat_y), .i_quat_z(i_quat_z),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_shaft_rotation(o_shaft_rotation), .i_shaft_tilt(o_shaft_tilt),
        .i_blade_rotation(o_blade_rotation), .i_no_heading(o_no_heading),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // Result side stalls at random according to the current phase.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= drain_stall_pct);
    end

    // Offers one quaternion, with random gaps beforehand, and waits for acceptance.
    task automatic offer_quat(input int w, input int x, input int y, input int z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_quat_w   <= QUAT_W'(w);
        i_quat_x   <= QUAT_W'(x);
        i_quat_y   <= QUAT_W'(y);
        i_quat_z   <= QUAT_W'(z);
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sent++;
        @(negedge i_clk);
    endtask

    // Random quaternion: mostly unit length, some raw 16-bit and some small values.
    task automatic offer_random_quat();
        real a, b, c, d, n;
        int  mode;
        mode = $urandom_range(9);
        if (mode < 6) begin
            a = real'($urandom_range(20000)) - 10000.0;
            b = real'($urandom_range(20000)) - 10000.0;
            c = real'($urandom_range(20000)) - 10000.0;
            d = real'($urandom_range(20000)) - 10000.0;
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) n = 1.0;
            offer_quat(int'(a * 16384.0 / n), int'(b * 16384.0 / n),
                       int'(c * 16384.0 / n), int'(d * 16384.0 / n));
        end else if (mode < 8) begin
            offer_quat($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                       $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
        end else begin
            offer_quat($urandom_range(8) - 4, $urandom_range(8) - 4,
                       $urandom_range(8) - 4, $urandom_range(8) - 4);
        end
    endtask

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 81, 0, 31};
        stall_tab = '{0, 0, 81, 31};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero, identity, axes, extremes, clamped tilt, reversed heading.
        offer_quat(0, 0, 0, 0);
        offer_quat(16384, 0, 0, 0);
        offer_quat(-16384, 0, 0, 0);
        offer_quat(0, 16384, 0, 0);
        offer_quat(0, 0, 16384, 0);
        offer_quat(0, 0, 0, 16384);
        offer_quat(0, -16384, 0, 0);
        offer_quat(0, 0, -16384, 0);
        offer_quat(0, 0, 0, -16384);
        offer_quat(16384, 16384, 0, 0);
        offer_quat(16384, -16384, 0, 0);
        offer_quat(11585, 11585, 0, 0);
        offer_quat(11585, -11585, 0, 0);
        offer_quat(11585, 0, 0, 11585);
        offer_quat(11585, 0, 0, -11585);
        offer_quat(11585, 0, 11585, 0);
        offer_quat(-32768, -32768, -32768, -32768);
        offer_quat(32767, 32767, 32767, 32767);
        offer_quat(32767, -32768, 32767, -32768);
        offer_quat(-32768, 0, 0, 0);
        offer_quat(0, 32767, 0, 0);
        offer_quat(1, 0, 0, 0);
        offer_quat(8192, 8192, 8192, 8192);
        offer_quat(-1, -1, -1, -1);

        // Random phases with different flow-control pressure on each side.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct   = idle_tab[p];
            drain_stall_pct = stall_tab[p];
            repeat (310) offer_random_quat();
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("Sent %0d quaternions, %0d results compared across four flow-control phases.",
                 sent, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop if the pipeline hangs.
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
